// ----- hdl/stq_pkg.sv -----
// Shared types, constants and time-compare functions of the sorted timer queue.
package stq_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int TIME_BITS  = 32;
   localparam int ID_BITS    = 4;
   localparam int DELAY_BITS = 31;
   localparam int OP_BITS    = 2;

   localparam logic [OP_BITS-1:0] OP_START   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_STOP    = 2'd1;
   localparam logic [OP_BITS-1:0] OP_PROCESS = 2'd2;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_REMOVE = 2'd1;
   localparam logic [1:0] CELL_INSERT = 2'd2;

   typedef struct packed {
      logic                 valid;
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] fire_time;
   } entry_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] fire_time;
      logic [TIME_BITS-1:0] now;
   } cell_cmd_type;

   function automatic logic t_less(input logic [TIME_BITS-1:0] a,
                                   input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] diff;
      diff = a - b;
      return diff[TIME_BITS-1];
   endfunction

   function automatic logic fires_before(input logic [TIME_BITS-1:0] a,
                                         input logic [TIME_BITS-1:0] b,
                                         input logic [TIME_BITS-1:0] now);
      logic a_past;
      logic b_past;
      a_past = t_less(a, now);
      b_past = t_less(b, now);
      if (a_past != b_past) begin
         return a_past;
      end
      return t_less(a, b);
   endfunction

endpackage

// ----- hdl/stq_req_if.sv -----
// Request channel carrying one timer operation word.
interface stq_req_if import stq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OP_BITS-1:0]    opcode;
   logic [TIME_BITS-1:0]  now;
   logic [ID_BITS-1:0]    timer_id;
   logic [TIME_BITS-1:0]  start_time;
   logic [DELAY_BITS-1:0] delay;

   modport source (output valid, opcode, now, timer_id, start_time, delay, input ready);
   modport sink   (input valid, opcode, now, timer_id, start_time, delay, output ready);
endinterface

// ----- hdl/stq_rsp_if.sv -----
// Response channel carrying one alarm and firing result word.
interface stq_rsp_if import stq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 alarm_update;
   logic                 alarm_armed;
   logic [TIME_BITS-1:0] alarm_remaining;
   logic                 fired_valid;
   logic [ID_BITS-1:0]   fired_id;

   modport source (output valid, alarm_update, alarm_armed, alarm_remaining, fired_valid,
                   fired_id, input ready);
   modport sink   (input valid, alarm_update, alarm_armed, alarm_remaining, fired_valid,
                   fired_id, output ready);
endinterface

// ----- hdl/stq_cell.sv -----
// One list cell holding a queued timer, shifting entries to and from its neighbors.
module stq_cell import stq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  entry_type    prev_entry,
   input  entry_type    next_entry,
   input  logic         chain_in,
   output logic         chain_out,
   output logic         hit,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      match;
   logic      goes_ahead;

   always_comb begin
      match      = entry_ff.valid && (entry_ff.id == cmd.id);
      goes_ahead = !entry_ff.valid ||
                   fires_before(cmd.fire_time, entry_ff.fire_time, cmd.now);
      entry_in = entry_ff;
      hit      = 1'b0;
      chain_out = chain_in;
      case (cmd.op)
         CELL_REMOVE: begin
            hit       = match;
            chain_out = chain_in || match;
            if (chain_in || match) begin
               entry_in = next_entry;
            end
         end
         CELL_INSERT: begin
            hit       = goes_ahead && !chain_in;
            chain_out = chain_in || goes_ahead;
            if (chain_in) begin
               entry_in = prev_entry;
            end else if (goes_ahead) begin
               entry_in.valid     = 1'b1;
               entry_in.id        = cmd.id;
               entry_in.fire_time = cmd.fire_time;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ----- hdl/sorted_timer_queue_core.sv -----
// Each accepted request word makes a remove pass, then an insert pass through the
// list cells; its result word is registered once the output register is free, and
// no new request word is accepted before that. A result waiting in the output
// register blocks only the loading, not the acceptance, of the next request.
// Reset clears the cell valid bits and the control state.
module sorted_timer_queue_core import stq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   stq_req_if.sink   req_if,
   stq_rsp_if.source rsp_if
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REMOVE = 2'd1;
   localparam logic [1:0] ST_INSERT = 2'd2;
   localparam logic [1:0] ST_RESP   = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [OP_BITS-1:0]   op_ff, op_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] ft_ff, ft_in;
   logic                 update_ff, update_in;
   logic                 fired_ff, fired_in;
   logic [ID_BITS-1:0]   fid_ff, fid_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_update_ff, out_update_in;
   logic                 out_armed_ff, out_armed_in;
   logic [TIME_BITS-1:0] out_remaining_ff, out_remaining_in;
   logic                 out_fired_ff, out_fired_in;
   logic [ID_BITS-1:0]   out_fid_ff, out_fid_in;

   cell_cmd_type         cmd;
   entry_type            ents [NUM_TIMERS];
   logic                 chain [NUM_TIMERS+1];
   logic                 hits [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] valid_vec;
   logic                 head_due;
   logic                 accept;
   logic                 load_out;

   assign chain[0] = 1'b0;

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;
      if (i == 0) begin : g_first
         assign prev_e = '0;
      end else begin : g_mid
         assign prev_e = ents[i-1];
      end
      if (i == NUM_TIMERS - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_inner
         assign next_e = ents[i+1];
      end
      stq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .hit        (hits[i]),
         .entry      (ents[i])
      );
      assign valid_vec[i] = ents[i].valid;
   end

   assign accept   = req_if.valid && req_if.ready;
   assign head_due = ents[0].valid && !t_less(now_ff, ents[0].fire_time);
   assign load_out = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      id_in     = id_ff;
      now_in    = now_ff;
      ft_in     = ft_ff;
      update_in = update_ff;
      fired_in  = fired_ff;
      fid_in    = fid_ff;
      cmd.op        = CELL_HOLD;
      cmd.id        = id_ff;
      cmd.fire_time = ft_ff;
      cmd.now       = now_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_if.opcode;
               id_in     = req_if.timer_id;
               now_in    = req_if.now;
               ft_in     = req_if.start_time + {1'b0, req_if.delay};
               update_in = 1'b0;
               fired_in  = 1'b0;
               fid_in    = '0;
               state_in  = ST_REMOVE;
            end
         end
         ST_REMOVE: begin
            if (op_ff == OP_START || op_ff == OP_STOP) begin
               cmd.op    = CELL_REMOVE;
               update_in = hits[0];
            end else if (op_ff == OP_PROCESS) begin
               update_in = 1'b1;
               if (head_due) begin
                  cmd.op   = CELL_REMOVE;
                  cmd.id   = ents[0].id;
                  fired_in = 1'b1;
                  fid_in   = ents[0].id;
               end
            end
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            if (op_ff == OP_START && !ents[NUM_TIMERS-1].valid) begin
               cmd.op    = CELL_INSERT;
               update_in = update_ff || hits[0];
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      out_update_in    = out_update_ff;
      out_armed_in     = out_armed_ff;
      out_remaining_in = out_remaining_ff;
      out_fired_in     = out_fired_ff;
      out_fid_in       = out_fid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in     = 1'b1;
         out_update_in    = update_ff;
         out_armed_in     = update_ff && ents[0].valid;
         out_remaining_in = '0;
         if (update_ff && ents[0].valid && t_less(now_ff, ents[0].fire_time)) begin
            out_remaining_in = ents[0].fire_time - now_ff;
         end
         out_fired_in     = fired_ff;
         out_fid_in       = fired_ff ? fid_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      id_ff            <= id_in;
      now_ff           <= now_in;
      ft_ff            <= ft_in;
      update_ff        <= update_in;
      fired_ff         <= fired_in;
      fid_ff           <= fid_in;
      out_update_ff    <= out_update_in;
      out_armed_ff     <= out_armed_in;
      out_remaining_ff <= out_remaining_in;
      out_fired_ff     <= out_fired_in;
      out_fid_ff       <= out_fid_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.alarm_update    = out_update_ff;
   assign rsp_if.alarm_armed     = out_armed_ff;
   assign rsp_if.alarm_remaining = out_remaining_ff;
   assign rsp_if.fired_valid     = out_fired_ff;
   assign rsp_if.fired_id        = out_fid_ff;

`ifndef SYNTHESIS
   a_list_packed: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + (NUM_TIMERS+1)'(1)))
      else $error("Queued timers do not form a packed list from the head.");

   a_fire_updates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_fired_ff |-> out_update_ff)
      else $error("A fired timer was reported without a matching alarm update.");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_REMOVE)
      else $error("An accepted word did not start the remove pass.");

   a_resp_loaded: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("A finished operation did not reach the output register.");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the sorted timer queue: random and directed operations checked against a predictor.
module tb_top;
   import stq_pkg::*;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_OPS = 1230;

   typedef struct packed {
      logic                  drain_first;
      logic [OP_BITS-1:0]    opcode;
      logic [TIME_BITS-1:0]  now;
      logic [ID_BITS-1:0]    id;
      logic [TIME_BITS-1:0]  start_time;
      logic [DELAY_BITS-1:0] delay;
   } timer_op_type;

   typedef struct packed {
      logic                 update;
      logic                 armed;
      logic [TIME_BITS-1:0] remaining;
      logic                 fired;
      logic [ID_BITS-1:0]   fired_id;
   } alarm_word_type;

   logic clock;
   logic reset;

   stq_req_if req_ch ();
   stq_rsp_if rsp_ch ();

   sorted_timer_queue_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   timer_op_type   ops_pending[$];
   alarm_word_type alarm_words_due[$];
   timer_op_type   op_on_bus;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          req_gap = 0;
   int          rsp_stall = 0;
   logic        req_steady = 1'b0;
   logic        rsp_steady = 1'b0;

   logic [TIME_BITS-1:0] slot_fire [NUM_TIMERS];
   logic                 slot_queued [NUM_TIMERS];
   logic [ID_BITS-1:0]   fire_order [NUM_TIMERS];
   int                   order_len;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic wraps_before(input logic [TIME_BITS-1:0] a,
                                         input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] gap;
      gap = a - b;
      return gap[TIME_BITS-1];
   endfunction

   function automatic logic fires_ahead(input logic [TIME_BITS-1:0] a,
                                        input logic [TIME_BITS-1:0] b,
                                        input logic [TIME_BITS-1:0] now);
      logic a_late;
      logic b_late;
      a_late = wraps_before(a, now);
      b_late = wraps_before(b, now);
      if (a_late != b_late) begin
         return a_late;
      end
      return wraps_before(a, b);
   endfunction

   // Takes a timer out of the firing order; tells whether it was at the head.
   function automatic logic unlink_timer(input logic [ID_BITS-1:0] id);
      int pos;
      pos = -1;
      if (!slot_queued[id]) begin
         return 1'b0;
      end
      slot_queued[id] = 1'b0;
      for (int i = order_len - 1; i >= 0; i--) begin
         if (fire_order[i] == id) begin
            pos = i;
         end
      end
      if (pos < 0) begin
         return 1'b0;
      end
      for (int i = pos; i + 1 < order_len; i++) begin
         fire_order[i] = fire_order[i + 1];
      end
      order_len--;
      return pos == 0;
   endfunction

   function automatic alarm_word_type next_alarm_word(input timer_op_type op);
      alarm_word_type       word;
      logic                 rearm;
      int                   pos;
      logic [TIME_BITS-1:0] ft;
      logic [ID_BITS-1:0]   head;
      word  = '0;
      rearm = 1'b0;
      case (op.opcode)
         OP_START: begin
            if (unlink_timer(op.id)) begin
               rearm = 1'b1;
            end
            ft = op.start_time + {1'b0, op.delay};
            slot_fire[op.id] = ft;
            pos = order_len;
            for (int i = order_len - 1; i >= 0; i--) begin
               if (fires_ahead(ft, slot_fire[fire_order[i]], op.now)) begin
                  pos = i;
               end
            end
            for (int i = order_len; i > pos; i--) begin
               fire_order[i] = fire_order[i - 1];
            end
            fire_order[pos] = op.id;
            order_len++;
            slot_queued[op.id] = 1'b1;
            if (pos == 0) begin
               rearm = 1'b1;
            end
         end
         OP_STOP: begin
            if (unlink_timer(op.id)) begin
               rearm = 1'b1;
            end
         end
         OP_PROCESS: begin
            rearm = 1'b1;
            if (order_len > 0) begin
               head = fire_order[0];
               if (!wraps_before(op.now, slot_fire[head])) begin
                  void'(unlink_timer(head));
                  word.fired    = 1'b1;
                  word.fired_id = head;
               end
            end
         end
         default: begin
         end
      endcase
      word.update = rearm;
      if (rearm && order_len > 0) begin
         head = fire_order[0];
         word.armed = 1'b1;
         if (wraps_before(op.now, slot_fire[head])) begin
            word.remaining = slot_fire[head] - op.now;
         end
      end
      return word;
   endfunction

   task automatic queue_op(input logic drain_first, input logic [OP_BITS-1:0] opcode,
                           input logic [31:0] now, input logic [31:0] id,
                           input logic [31:0] start_time, input logic [31:0] delay);
      timer_op_type op;
      op.drain_first = drain_first;
      op.opcode      = opcode;
      op.now         = now;
      op.id          = id[ID_BITS-1:0];
      op.start_time  = start_time;
      op.delay       = delay[DELAY_BITS-1:0];
      ops_pending.push_back(op);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : drive_req
      logic send;
      send = 1'b0;
      if (reset) begin
         req_ch.valid <= 1'b0;
         order_len = 0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            slot_queued[i] = 1'b0;
         end
      end else begin
         if ($urandom_range(0, 63) == 0) begin
            req_steady = !req_steady;
         end
         if (req_ch.valid && req_ch.ready) begin
            alarm_words_due.push_back(next_alarm_word(op_on_bus));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (ops_pending.size() > 0) begin
               if (ops_pending[0].drain_first) begin
                  if (alarm_words_due.size() == 0) begin
                     void'(ops_pending.pop_front());
                  end
               end else if (!req_steady && ops_pending.size() > 100 &&
                            $urandom_range(0, 3) == 0) begin
                  req_gap = $urandom_range(0, 5);
               end else begin
                  op_on_bus = ops_pending.pop_front();
                  send = 1'b1;
               end
            end
            req_ch.valid <= send;
            if (send) begin
               req_ch.opcode     <= op_on_bus.opcode;
               req_ch.now        <= op_on_bus.now;
               req_ch.timer_id   <= op_on_bus.id;
               req_ch.start_time <= op_on_bus.start_time;
               req_ch.delay      <= op_on_bus.delay;
            end
         end
      end
   end

   always @(posedge clock) begin : take_rsp
      alarm_word_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) begin
            rsp_steady = !rsp_steady;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (alarm_words_due.size() == 0) begin
               $display("%0t ns: word with none expected, actual %0h %0h %0h %0h %0h",
                        $time, rsp_ch.alarm_update, rsp_ch.alarm_armed,
                        rsp_ch.alarm_remaining, rsp_ch.fired_valid, rsp_ch.fired_id);
               mismatch_count++;
            end else begin
               want = alarm_words_due.pop_front();
               check_field("alarm_update", 32'(want.update), 32'(rsp_ch.alarm_update));
               check_field("alarm_armed", 32'(want.armed), 32'(rsp_ch.alarm_armed));
               check_field("alarm_remaining", want.remaining, rsp_ch.alarm_remaining);
               check_field("fired_valid", 32'(want.fired), 32'(rsp_ch.fired_valid));
               check_field("fired_id", 32'(want.fired_id), 32'(rsp_ch.fired_id));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else if (!rsp_steady && ops_pending.size() > 100 &&
                      $urandom_range(0, 3) == 0) begin
            rsp_stall = $urandom_range(0, 5);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      logic [TIME_BITS-1:0] t_now;
      logic [31:0]          rnd_a;
      logic [31:0]          rnd_b;
      int                   pick;
      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_START;
      req_ch.now        = '0;
      req_ch.timer_id   = '0;
      req_ch.start_time = '0;
      req_ch.delay      = '0;
      rsp_ch.ready      = 1'b0;

      queue_op(1'b0, OP_PROCESS, 0, 0, 0, 0);
      queue_op(1'b0, OP_STOP, 0, 5, 0, 0);
      queue_op(1'b0, OP_UNUSED, 32'hFFFF_FFFF, 15, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      queue_op(1'b0, OP_START, 100, 0, 100, 0);
      queue_op(1'b0, OP_START, 100, 15, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      queue_op(1'b0, OP_START, 100, 3, 100, 50);
      queue_op(1'b0, OP_START, 100, 4, 140, 10);
      queue_op(1'b0, OP_START, 100, 7, 0, 20);
      queue_op(1'b0, OP_PROCESS, 110, 0, 0, 0);
      queue_op(1'b0, OP_PROCESS, 110, 0, 0, 0);
      queue_op(1'b0, OP_PROCESS, 120, 0, 0, 0);
      queue_op(1'b0, OP_START, 120, 3, 120, 100);
      queue_op(1'b0, OP_STOP, 130, 4, 0, 0);
      queue_op(1'b0, OP_STOP, 130, 4, 0, 0);
      queue_op(1'b0, OP_START, 130, 1, 130, 32'h7FFF_FFFF);
      queue_op(1'b0, OP_PROCESS, 150, 0, 0, 0);
      queue_op(1'b0, OP_PROCESS, 220, 0, 0, 0);
      queue_op(1'b0, OP_START, 32'hFFFF_FFF0, 8, 32'hFFFF_FFF0, 32);
      queue_op(1'b0, OP_PROCESS, 32'hFFFF_FFFF, 0, 0, 0);
      queue_op(1'b0, OP_PROCESS, 32'h10, 0, 0, 0);
      queue_op(1'b0, OP_STOP, 32'h10, 1, 0, 0);
      queue_op(1'b0, OP_STOP, 32'h10, 15, 0, 0);
      queue_op(1'b1, OP_START, 0, 0, 0, 0);

      // Mostly well-formed traffic on a slowly advancing clock, so that timers
      // actually come due; the rest is noise over the full field ranges.
      t_now = $urandom;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 300 == 150) begin
            queue_op(1'b1, OP_START, 0, 0, 0, 0);
         end
         if ($urandom_range(0, 199) == 0) begin
            t_now = 32'hFFFF_FF00 | $urandom_range(0, 255);
         end
         t_now = t_now + $urandom_range(0, 24);
         pick  = $urandom_range(0, 99);
         rnd_a = $urandom;
         rnd_b = $urandom;
         if (pick < 28) begin
            queue_op(1'b0, OP_START, t_now, $urandom_range(0, 15),
                     t_now - $urandom_range(0, 8), $urandom_range(0, 20) * 8);
         end else if (pick < 36) begin
            queue_op(1'b0, OP_START, t_now, $urandom_range(0, 15),
                     t_now - $urandom_range(0, 400), $urandom_range(0, 100));
         end else if (pick < 40) begin
            queue_op(1'b0, OP_START, t_now, $urandom_range(0, 15), rnd_b, rnd_a);
         end else if (pick < 55) begin
            queue_op(1'b0, OP_STOP, t_now, $urandom_range(0, 15), rnd_a, rnd_b);
         end else if (pick < 92) begin
            queue_op(1'b0, OP_PROCESS, t_now, rnd_a, rnd_b, $urandom);
         end else if (pick < 98) begin
            queue_op(1'b0, OP_BITS'($urandom_range(0, 2)), rnd_a, $urandom, rnd_b, $urandom);
         end else begin
            queue_op(1'b0, OP_UNUSED, rnd_a, $urandom, rnd_b, $urandom);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (ops_pending.size() != 0 || req_ch.valid || alarm_words_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (12) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
